// ===== hdl/rkco_pkg.sv =====
package rkco_pkg;

    localparam int NUM_EQ = 4;

    // configuration register indexes
    localparam logic [2:0] REG_STEP_SIZE = 3'd0;
    localparam logic [2:0] REG_COEF_A    = 3'd1;
    localparam logic [2:0] REG_COEF_B    = 3'd2;
    localparam logic [2:0] REG_COEF_C    = 3'd3;
    localparam logic [2:0] REG_INIT_POS1 = 3'd4;
    localparam logic [2:0] REG_INIT_POS2 = 3'd5;
    localparam logic [2:0] REG_INIT_VEL1 = 3'd6;
    localparam logic [2:0] REG_INIT_VEL2 = 3'd7;

    // reset values of the configuration registers
    localparam logic [16:0]        RST_STEP_SIZE = 17'd6554;
    localparam logic [30:0]        RST_COEF_A    = 31'd81920;
    localparam logic [30:0]        RST_COEF_B    = 31'd114688;
    localparam logic [30:0]        RST_COEF_C    = 31'd65536;
    localparam logic signed [31:0] RST_INIT_POS1 = 32'sd196608;
    localparam logic signed [31:0] RST_INIT_POS2 = 32'sd262144;
    localparam logic signed [31:0] RST_INIT_VEL1 = 32'sd0;
    localparam logic signed [31:0] RST_INIT_VEL2 = 32'sd0;

    // multiplier operations within one slope evaluation
    localparam logic [2:0] OP_AX1   = 3'd0;
    localparam logic [2:0] OP_BDIFF = 3'd1;
    localparam logic [2:0] OP_CDIFF = 3'd2;
    localparam logic [2:0] OP_HV1   = 3'd3;
    localparam logic [2:0] OP_HV2   = 3'd4;
    localparam logic [2:0] OP_HD2   = 3'd5;
    localparam logic [2:0] OP_HD3   = 3'd6;
    localparam logic [2:0] OP_LAST  = OP_HD3;

    localparam logic [1:0] STAGE_LAST = 2'd3;

    // divide by six: offset dividend, long division DIV_STEPS quotient bits per cycle
    localparam int DIV_BITS   = 35;
    localparam int DIV_STEPS  = 7;
    localparam int DIV_CYCLES = DIV_BITS / DIV_STEPS;
    localparam logic [2:0] DIV_CNT_LAST = 3'(DIV_CYCLES - 1);
    localparam logic [3:0] DIVISOR = 4'd6;
    // 6 * 2^31, a multiple of six that keeps the dividend nonnegative
    localparam logic signed [35:0] DIV_OFFSET = 36'sh3_0000_0000;
    localparam logic signed [32:0] QUO_OFFSET = 33'sh0_8000_0000;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    typedef struct packed {
        logic              clip;
        logic signed [31:0] val;
    } sat_t;

    function automatic sat_t sat32(input logic signed [65:0] v);
        sat_t r;
        if (v > SAT_MAX) begin
            r.clip = 1'b1;
            r.val  = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r.clip = 1'b1;
            r.val  = 32'sh8000_0000;
        end else begin
            r.clip = 1'b0;
            r.val  = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/rk4_coupled_oscillator_step.sv =====
// Two coupled masses advanced by classic fourth-order Runge-Kutta in signed fixed point
// with FRAC_BITS fraction bits. A request with restart high reloads the initial
// registers and clears the step count; its result appears in the cycle after acceptance.
// A request with restart low takes one step of size h through the states ST_RUN on the
// one shared 32x32 multiplier (seven products for each of the four slope evaluations,
// issued back to back), ST_DRAIN to drain the multiplier register, ST_DIV for
// divide-by-six (seven quotient bits a cycle, four lanes) and ST_FIN to update the state.
// The block takes one request at a time: s_ready is high only while no request is in
// work and no result waits, so the next request is accepted the cycle after the result
// is taken. Configuration must be written only while idle; this is not enforced.
module rk4_coupled_oscillator_step #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_restart,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_step_count,
    output logic signed [31:0] m_pos1,
    output logic signed [31:0] m_pos2,
    output logic signed [31:0] m_vel1,
    output logic signed [31:0] m_vel2,
    output logic               m_saturated
);
    import rkco_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] op_reg;
    logic [1:0] stage_reg;
    logic       post_vld_reg;
    logic [2:0] post_op_reg;
    logic [1:0] post_stage_reg;
    logic [2:0] div_cnt_reg;
    logic [15:0] count_reg;
    logic        clip_reg;

    logic [16:0]        step_size_reg;
    logic [30:0]        coef_a_reg, coef_b_reg, coef_c_reg;
    logic signed [31:0] init_pos1_reg, init_pos2_reg, init_vel1_reg, init_vel2_reg;

    logic signed [31:0] y_reg  [NUM_EQ];
    logic signed [31:0] yy_reg [NUM_EQ];
    logic signed [35:0] sum_reg [NUM_EQ];
    logic [DIV_BITS-1:0] div_val_reg [NUM_EQ];
    logic [2:0]          div_rem_reg [NUM_EQ];
    logic [DIV_BITS-1:0] div_val_next [NUM_EQ];
    logic [2:0]          div_rem_next [NUM_EQ];

    logic signed [63:0] prod_reg;
    logic signed [64:0] acc_reg;
    logic signed [31:0] d2_reg, d3_reg;

    logic in_accept;
    logic signed [31:0] mul_a, mul_b;
    logic signed [31:0] h_op;
    sat_t diff_sat;
    logic signed [63:0] post_sh;
    sat_t post_sat;
    sat_t d2_sat;
    logic        post_is_k;
    logic [1:0]  post_idx;
    logic signed [31:0] k_add;
    sat_t yy_sat;
    logic        post_clip;
    sat_t fin_sat [NUM_EQ];
    logic        fin_clip;
    logic        clip_now;

    assign in_accept = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_OUT);
    assign m_step_count = count_reg;
    assign m_pos1 = y_reg[0];
    assign m_pos2 = y_reg[1];
    assign m_vel1 = y_reg[2];
    assign m_vel2 = y_reg[3];
    assign m_saturated = clip_reg;

    assign diff_sat = sat32(66'(yy_reg[0]) - 66'(yy_reg[1]));
    assign h_op     = {15'd0, step_size_reg};

    // operand select for the shared multiplier
    always_comb begin
        case (op_reg)
            OP_AX1: begin
                mul_a = {1'b0, coef_a_reg};
                mul_b = yy_reg[0];
            end
            OP_BDIFF: begin
                mul_a = {1'b0, coef_b_reg};
                mul_b = diff_sat.val;
            end
            OP_CDIFF: begin
                mul_a = {1'b0, coef_c_reg};
                mul_b = diff_sat.val;
            end
            OP_HV1: begin
                mul_a = h_op;
                mul_b = yy_reg[2];
            end
            OP_HV2: begin
                mul_a = h_op;
                mul_b = yy_reg[3];
            end
            OP_HD2: begin
                mul_a = h_op;
                mul_b = d2_reg;
            end
            OP_HD3: begin
                mul_a = h_op;
                mul_b = d3_reg;
            end
            default: begin
                mul_a = h_op;
                mul_b = yy_reg[0];
            end
        endcase
    end

    // post-processing of the registered product
    assign post_sh   = prod_reg >>> FRAC_BITS;
    assign post_sat  = sat32(66'(post_sh));
    assign d2_sat    = sat32(66'(acc_reg) - 66'(post_sh));
    assign post_is_k = (post_op_reg >= OP_HV1);
    assign post_idx  = 2'(post_op_reg - OP_HV1);
    // third stage adds the full slope, first two add half
    assign k_add     = (post_stage_reg == 2'd2) ? post_sat.val : (post_sat.val >>> 1);
    assign yy_sat    = sat32(66'(y_reg[post_idx]) + 66'(k_add));

    always_comb begin
        post_clip = 1'b0;
        if (post_vld_reg) begin
            case (post_op_reg)
                OP_AX1:   post_clip = 1'b0;
                OP_BDIFF: post_clip = d2_sat.clip;
                OP_CDIFF: post_clip = post_sat.clip;
                default:  post_clip = post_sat.clip
                                    | ((post_stage_reg != STAGE_LAST) & yy_sat.clip);
            endcase
        end
    end

    // divide by six, four lanes, DIV_STEPS quotient bits a cycle
    always_comb begin
        logic [DIV_BITS-1:0] val;
        logic [2:0]          rem;
        logic [3:0]          r4;
        for (int j = 0; j < NUM_EQ; j++) begin
            if (div_cnt_reg == 3'd0) begin
                val = DIV_BITS'(sum_reg[j] + DIV_OFFSET);
                rem = 3'd0;
            end else begin
                val = div_val_reg[j];
                rem = div_rem_reg[j];
            end
            for (int i = 0; i < DIV_STEPS; i++) begin
                r4  = {rem, val[DIV_BITS-1]};
                val = {val[DIV_BITS-2:0], 1'b0};
                if (r4 >= DIVISOR) begin
                    rem    = 3'(r4 - DIVISOR);
                    val[0] = 1'b1;
                end else begin
                    rem = r4[2:0];
                end
            end
            div_val_next[j] = val;
            div_rem_next[j] = rem;
        end
    end

    always_comb begin
        fin_clip = 1'b0;
        for (int j = 0; j < NUM_EQ; j++) begin
            fin_sat[j] = sat32(66'(y_reg[j])
                             + 66'($signed({1'b0, div_val_reg[j][31:0]}) - QUO_OFFSET));
            fin_clip   = fin_clip | fin_sat[j].clip;
        end
    end

    assign clip_now = ((state_reg == ST_RUN) && (op_reg == OP_BDIFF) && diff_sat.clip)
                    | post_clip
                    | ((state_reg == ST_FIN) && fin_clip);

    // control, configuration and state vector
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_AX1;
            stage_reg      <= 2'd0;
            post_vld_reg   <= 1'b0;
            post_op_reg    <= OP_AX1;
            post_stage_reg <= 2'd0;
            div_cnt_reg    <= 3'd0;
            count_reg      <= 16'd0;
            clip_reg       <= 1'b0;
            step_size_reg  <= RST_STEP_SIZE;
            coef_a_reg     <= RST_COEF_A;
            coef_b_reg     <= RST_COEF_B;
            coef_c_reg     <= RST_COEF_C;
            init_pos1_reg  <= RST_INIT_POS1;
            init_pos2_reg  <= RST_INIT_POS2;
            init_vel1_reg  <= RST_INIT_VEL1;
            init_vel2_reg  <= RST_INIT_VEL2;
            y_reg[0]       <= RST_INIT_POS1;
            y_reg[1]       <= RST_INIT_POS2;
            y_reg[2]       <= RST_INIT_VEL1;
            y_reg[3]       <= RST_INIT_VEL2;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_STEP_SIZE: step_size_reg <= cfg_wdata[16:0];
                    REG_COEF_A:    coef_a_reg    <= cfg_wdata[30:0];
                    REG_COEF_B:    coef_b_reg    <= cfg_wdata[30:0];
                    REG_COEF_C:    coef_c_reg    <= cfg_wdata[30:0];
                    REG_INIT_POS1: init_pos1_reg <= cfg_wdata;
                    REG_INIT_POS2: init_pos2_reg <= cfg_wdata;
                    REG_INIT_VEL1: init_vel1_reg <= cfg_wdata;
                    REG_INIT_VEL2: init_vel2_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            post_vld_reg   <= (state_reg == ST_RUN);
            post_op_reg    <= op_reg;
            post_stage_reg <= stage_reg;

            if (in_accept) begin
                clip_reg <= 1'b0;
            end else begin
                clip_reg <= clip_reg | clip_now;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        op_reg    <= OP_AX1;
                        stage_reg <= 2'd0;
                        if (s_restart) begin
                            y_reg[0]  <= init_pos1_reg;
                            y_reg[1]  <= init_pos2_reg;
                            y_reg[2]  <= init_vel1_reg;
                            y_reg[3]  <= init_vel2_reg;
                            count_reg <= 16'd0;
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    if (op_reg == OP_LAST) begin
                        op_reg <= OP_AX1;
                        if (stage_reg == STAGE_LAST) begin
                            state_reg <= ST_DRAIN;
                        end else begin
                            stage_reg <= stage_reg + 2'd1;
                        end
                    end else begin
                        op_reg <= op_reg + 3'd1;
                    end
                end
                ST_DRAIN: begin
                    div_cnt_reg <= 3'd0;
                    state_reg   <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_cnt_reg == DIV_CNT_LAST) begin
                        div_cnt_reg <= 3'd0;
                        state_reg   <= ST_FIN;
                    end else begin
                        div_cnt_reg <= div_cnt_reg + 3'd1;
                    end
                end
                ST_FIN: begin
                    for (int j = 0; j < NUM_EQ; j++) begin
                        y_reg[j] <= fin_sat[j].val;
                    end
                    if (count_reg != COUNT_MAX) begin
                        count_reg <= count_reg + 16'd1;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            for (int j = 0; j < NUM_EQ; j++) begin
                yy_reg[j] <= y_reg[j];
            end
        end

        if (state_reg == ST_RUN) begin
            prod_reg <= mul_a * mul_b;
        end

        if (post_vld_reg) begin
            case (post_op_reg)
                OP_AX1:   acc_reg <= -65'(post_sh);
                OP_BDIFF: d2_reg  <= d2_sat.val;
                OP_CDIFF: d3_reg  <= post_sat.val;
                default: ;
            endcase
            if (post_is_k) begin
                // slot of each slope is free again once its multiply has issued
                if (post_stage_reg != STAGE_LAST) begin
                    yy_reg[post_idx] <= yy_sat.val;
                end
                case (post_stage_reg)
                    2'd0:    sum_reg[post_idx] <= 36'(post_sat.val);
                    2'd3:    sum_reg[post_idx] <= sum_reg[post_idx] + 36'(post_sat.val);
                    default: sum_reg[post_idx] <= sum_reg[post_idx]
                                                + (36'(post_sat.val) <<< 1);
                endcase
            end
        end

        if (state_reg == ST_DIV) begin
            for (int j = 0; j < NUM_EQ; j++) begin
                div_val_reg[j] <= div_val_next[j];
                div_rem_reg[j] <= div_rem_next[j];
            end
        end
    end

endmodule
